// File: sv/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared constants, opcode and pipeline control types for the spline evaluator.
// ----------------------------------------------------------------------------
package crs_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int MIN_POINTS      = 2;
	localparam int POINT_COUNT_RST = 2;

	// control points live in four interleaved banks so that four neighbors
	// can be read in the same cycle
	localparam int NUM_BANKS  = 4;
	localparam int BANK_SEL_W = 2;

	// stage map: 0 store read, 1 tangent, 2 reciprocal multiply,
	// 3 bezier points, then three lerp rounds, then the output register
	localparam int LERP_STAGES = 3;
	localparam int STG_ROUND1  = 4;
	localparam int STG_ROUND2  = STG_ROUND1 + LERP_STAGES;
	localparam int STG_ROUND3  = STG_ROUND2 + LERP_STAGES;
	localparam int STG_OUT     = STG_ROUND3 + LERP_STAGES;
	localparam int NUM_STAGES  = STG_OUT + 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [BANK_SEL_W-1:0] rot;
		logic                  tan0_zero;
		logic                  tan1_zero;
	} ctl_t;

endpackage

// File: sv/crs_ram.sv
// ----------------------------------------------------------------------------
// crs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/crs_lerp.sv
// ----------------------------------------------------------------------------
// crs_lerp
// Three stage linear interpolation a + floor((b - a) * f / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module crs_lerp #(
	parameter int W         = crs_pkg::COORD_WIDTH_DEF + 1,
	parameter int FRAC_BITS = crs_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic [2:0]           en,
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	input  logic [FRAC_BITS-1:0] f,
	output logic signed [W-1:0]  res
);

	localparam int DW = W + 1;
	localparam int PW = DW + FRAC_BITS + 1;

	logic signed [W-1:0]  a_s1;
	logic signed [DW-1:0] d_s1;
	logic [FRAC_BITS-1:0] f_s1;
	logic signed [W-1:0]  a_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] shifted;
	logic signed [W-1:0]  res_s3;

	// result stays between a and b, so the shifted product fits in W bits
	assign shifted = prod_s2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1 <= a;
			d_s1 <= DW'(b) - DW'(a);
			f_s1 <= f;
		end
		if (en[1]) begin
			a_s2    <= a_s1;
			prod_s2 <= d_s1 * $signed({1'b0, f_s1});
		end
		if (en[2]) begin
			res_s3 <= a_s2 + $signed(shifted[W-1:0]);
		end
	end

	assign res = res_s3;

endmodule

// File: sv/crs_axis.sv
// ----------------------------------------------------------------------------
// crs_axis
// One coordinate axis: tangents, bezier inner points and de Casteljau rounds.
// ----------------------------------------------------------------------------
module crs_axis #(
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = crs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  crs_pkg::ctl_t                 ctl,
	input  logic [COORD_WIDTH-1:0]        bank_rd [crs_pkg::NUM_BANKS],
	input  logic [FRAC_BITS-1:0]          frac_r1,
	input  logic [FRAC_BITS-1:0]          frac_r2,
	input  logic [FRAC_BITS-1:0]          frac_r3,
	output logic signed [COORD_WIDTH-1:0] curve
);
	import crs_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int W  = CW + 1;
	localparam int UW = CW + 1;
	// ceil(2^(UW+1) / 3): exact floor divide by three for any UW-bit value
	localparam logic [UW-1:0] RECIP  = UW'(((64'd1 << (UW + 1)) + 64'd2) / 64'd3);
	localparam logic [UW-1:0] OFFSET = UW'(64'd3 << (CW - 1));
	localparam logic signed [W-1:0] HALF = W'(64'd1 << (CW - 1));
	localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW - 1){1'b0}}};

	logic signed [CW-1:0] slot [NUM_BANKS];
	logic signed [CW:0]   dif0, dif1;
	logic signed [CW-1:0] tan0, tan1;

	logic [UW-1:0]        u0_s2, u1_s2;
	logic signed [CW-1:0] p1_s2, p2_s2;
	logic [2*UW-1:0]      prod0_s3, prod1_s3;
	logic signed [CW-1:0] p1_s3, p2_s3;
	logic [CW-1:0]        quo0, quo1;
	logic signed [W-1:0]  ft0, ft1;
	logic signed [W-1:0]  c0_s4, c1_s4, c2_s4, c3_s4;

	logic signed [W-1:0]  r1_0, r1_1, r1_2;
	logic signed [W-1:0]  r2_0, r2_1;
	logic signed [W-1:0]  r3_0;
	logic [CW-1:0]        sat;
	logic signed [CW-1:0] res_s14;

	// slot m holds point (segment - 1 + m)
	always_comb begin
		for (int m = 0; m < NUM_BANKS; m++) begin
			slot[m] = bank_rd[BANK_SEL_W'(ctl.rot + BANK_SEL_W'(m))];
		end
	end

	always_comb begin
		dif0 = {slot[2][CW-1], slot[2]} - {slot[0][CW-1], slot[0]};
		dif1 = {slot[3][CW-1], slot[3]} - {slot[1][CW-1], slot[1]};
		tan0 = ctl.tan0_zero ? '0 : dif0[CW:1];
		tan1 = ctl.tan1_zero ? '0 : dif1[CW:1];
	end

	// tangents are biased positive so the divide by three is unsigned
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			u0_s2 <= {tan0[CW-1], tan0} + OFFSET;
			u1_s2 <= {tan1[CW-1], tan1} + OFFSET;
			p1_s2 <= slot[1];
			p2_s2 <= slot[2];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			prod0_s3 <= u0_s2 * RECIP;
			prod1_s3 <= u1_s2 * RECIP;
			p1_s3    <= p1_s2;
			p2_s3    <= p2_s2;
		end
	end

	always_comb begin
		quo0 = prod0_s3[2*UW-1:UW+1];
		quo1 = prod1_s3[2*UW-1:UW+1];
		ft0  = $signed({1'b0, quo0}) - HALF;
		ft1  = $signed({1'b0, quo1}) - HALF;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			c0_s4 <= W'(p1_s3);
			c1_s4 <= W'(p1_s3) + ft0;
			c2_s4 <= W'(p2_s3) - ft1;
			c3_s4 <= W'(p2_s3);
		end
	end

	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l10 (
		.clk(clk), .en(ctl.en[STG_ROUND1 +: LERP_STAGES]),
		.a(c0_s4), .b(c1_s4), .f(frac_r1), .res(r1_0)
	);
	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l11 (
		.clk(clk), .en(ctl.en[STG_ROUND1 +: LERP_STAGES]),
		.a(c1_s4), .b(c2_s4), .f(frac_r1), .res(r1_1)
	);
	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l12 (
		.clk(clk), .en(ctl.en[STG_ROUND1 +: LERP_STAGES]),
		.a(c2_s4), .b(c3_s4), .f(frac_r1), .res(r1_2)
	);
	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l20 (
		.clk(clk), .en(ctl.en[STG_ROUND2 +: LERP_STAGES]),
		.a(r1_0), .b(r1_1), .f(frac_r2), .res(r2_0)
	);
	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l21 (
		.clk(clk), .en(ctl.en[STG_ROUND2 +: LERP_STAGES]),
		.a(r1_1), .b(r1_2), .f(frac_r2), .res(r2_1)
	);
	crs_lerp #(.W(W), .FRAC_BITS(FRAC_BITS)) u_l30 (
		.clk(clk), .en(ctl.en[STG_ROUND3 +: LERP_STAGES]),
		.a(r2_0), .b(r2_1), .f(frac_r3), .res(r3_0)
	);

	always_comb begin
		if (r3_0[W-1] != r3_0[W-2]) begin
			sat = r3_0[W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			sat = r3_0[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_OUT]) begin
			res_s14 <= $signed(sat);
		end
	end

	assign curve = res_s14;

endmodule

// File: sv/catmull_rom_spline_eval.sv
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval
// 2D Catmull-Rom style spline evaluator with a loadable control point store.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one transaction per cycle:
// opcode OP_LOAD writes point_x / point_y to point_index, OP_EVAL evaluates
// the spline at param (segment index above FRAC_BITS, fraction below).
// A load gives no output; it is visible to an evaluate accepted on the next
// cycle. Each evaluate gives one output transaction (curve_x, curve_y,
// out_of_range) on out_valid / out_stall, in order.
// An evaluate passes 14 register stages before out_valid rises for it:
// store read, tangent, divide by three, bezier points, three lerp rounds
// of three stages each (subtract, multiply, add) and the saturating output
// register.
// Throughput is one transaction per cycle while in_stall is low; the four
// store banks give the four neighboring points of a segment in one read.
// cfg_wr_en / cfg_wr_data write point_count; write it only while idle.
// Reset empties the pipeline and sets point_count to 2; point store contents
// stay undefined until loaded.
// When out_stall holds a result, empty stages still fill; in_stall rises
// only once every stage holds an evaluate.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval #(
	parameter int  MAX_POINTS  = crs_pkg::MAX_POINTS_DEF,
	parameter int  COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
	parameter int  FRAC_BITS   = crs_pkg::FRAC_BITS_DEF,
	localparam int IDX_W       = $clog2(MAX_POINTS),
	localparam int CNT_W       = $clog2(MAX_POINTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CNT_W-1:0]              cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  crs_pkg::op_t                  opcode,
	input  logic [IDX_W-1:0]              point_index,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic [IDX_W+FRAC_BITS-1:0]    param,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] curve_x,
	output logic signed [COORD_WIDTH-1:0] curve_y,
	output logic                          out_of_range
);
	import crs_pkg::*;

	localparam int CW        = COORD_WIDTH;
	localparam int NSTG      = NUM_STAGES;
	localparam int BA_W      = (IDX_W > BANK_SEL_W) ? IDX_W - BANK_SEL_W : 1;
	localparam int RAM_DEPTH = 1 << BA_W;
	localparam int CMP_W     = IDX_W + 2;
	localparam int FRAC_STG  = STG_ROUND3;

	logic [CNT_W-1:0]     point_count_q;
	logic [NSTG-1:0]      vld_s;
	logic [NSTG-1:0]      oor_s;
	logic [NSTG-1:0]      en;
	logic [FRAC_BITS-1:0] frac_s [FRAC_STG];

	logic [CNT_W-1:0]      n_use;
	logic [CNT_W-1:0]      n_last;
	logic [IDX_W-1:0]      seg;
	logic                  oor;
	logic [IDX_W-1:0]      b_idx;
	logic [IDX_W-1:0]      base_idx;
	logic [BANK_SEL_W-1:0] rot;
	logic                  tan0_zero, tan1_zero;
	logic [IDX_W-1:0]      rd_idx [NUM_BANKS];
	logic [BA_W-1:0]       rd_addr [NUM_BANKS];
	logic                  load_we;

	logic [BANK_SEL_W-1:0] rot_s1;
	logic                  tz0_s1, tz1_s1;
	logic [2*CW-1:0]       bank_rd [NUM_BANKS];
	logic [CW-1:0]         bank_x [NUM_BANKS];
	logic [CW-1:0]         bank_y [NUM_BANKS];
	ctl_t                  ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(POINT_COUNT_RST);
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	// a stage moves when out_stall is low or any stage from it to the output is empty
	always_comb begin
		for (int k = 0; k < NSTG; k++) begin
			en[k] = !out_stall || ((vld_s >> k) != ({NSTG{1'b1}} >> k));
		end
	end

	assign in_stall = !en[0];
	assign load_we  = in_valid && en[0] && (opcode == OP_LOAD)
		&& ((IDX_W + 1)'(point_index) < (IDX_W + 1)'(MAX_POINTS));

	always_comb begin
		priority if (point_count_q < CNT_W'(MIN_POINTS)) begin
			n_use = CNT_W'(MIN_POINTS);
		end else if (point_count_q > CNT_W'(MAX_POINTS)) begin
			n_use = CNT_W'(MAX_POINTS);
		end else begin
			n_use = point_count_q;
		end
	end

	// past the last curve: evaluate at the last point with zero fraction
	always_comb begin
		n_last    = n_use - CNT_W'(1);
		seg       = param[IDX_W+FRAC_BITS-1:FRAC_BITS];
		oor       = CMP_W'(seg) >= CMP_W'(n_last);
		b_idx     = oor ? n_last[IDX_W-1:0] : seg;
		base_idx  = b_idx - IDX_W'(1);
		rot       = base_idx[BANK_SEL_W-1:0];
		tan0_zero = (b_idx == '0);
		tan1_zero = (CMP_W'(b_idx) + CMP_W'(2)) >= CMP_W'(n_use);
		for (int k = 0; k < NUM_BANKS; k++) begin
			rd_idx[k]  = base_idx + IDX_W'(BANK_SEL_W'(BANK_SEL_W'(k) - rot));
			rd_addr[k] = BA_W'(rd_idx[k] >> BANK_SEL_W);
		end
	end

	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		crs_ram #(.WIDTH(2 * CW), .DEPTH(RAM_DEPTH)) u_ram (
			.clk    (clk),
			.wr_en  (load_we && (point_index[BANK_SEL_W-1:0] == BANK_SEL_W'(k))),
			.wr_addr(BA_W'(point_index >> BANK_SEL_W)),
			.wr_data({point_x, point_y}),
			.rd_en  (en[0]),
			.rd_addr(rd_addr[k]),
			.rd_data(bank_rd[k])
		);
		assign bank_x[k] = bank_rd[k][2*CW-1:CW];
		assign bank_y[k] = bank_rd[k][CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid && (opcode == OP_EVAL);
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			oor_s[0]  <= oor;
			frac_s[0] <= oor ? '0 : param[FRAC_BITS-1:0];
			rot_s1    <= rot;
			tz0_s1    <= tan0_zero;
			tz1_s1    <= tan1_zero;
		end
		for (int k = 1; k < NSTG; k++) begin
			if (en[k]) begin
				oor_s[k] <= oor_s[k-1];
			end
		end
		for (int k = 1; k < FRAC_STG; k++) begin
			if (en[k]) begin
				frac_s[k] <= frac_s[k-1];
			end
		end
	end

	always_comb begin
		ctl.en        = en;
		ctl.rot       = rot_s1;
		ctl.tan0_zero = tz0_s1;
		ctl.tan1_zero = tz1_s1;
	end

	crs_axis #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk    (clk),
		.ctl    (ctl),
		.bank_rd(bank_x),
		.frac_r1(frac_s[STG_ROUND1-1]),
		.frac_r2(frac_s[STG_ROUND2-1]),
		.frac_r3(frac_s[STG_ROUND3-1]),
		.curve  (curve_x)
	);

	crs_axis #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk    (clk),
		.ctl    (ctl),
		.bank_rd(bank_y),
		.frac_r1(frac_s[STG_ROUND1-1]),
		.frac_r2(frac_s[STG_ROUND2-1]),
		.frac_r3(frac_s[STG_ROUND3-1]),
		.curve  (curve_y)
	);

	assign out_valid    = vld_s[NSTG-1];
	assign out_of_range = oor_s[NSTG-1];

endmodule

// File: verif/spline_eval_checker.sv
// ----------------------------------------------------------------------------
// spline_eval_checker
// Watches both channels and the point_count write port of the spline
// evaluator. It keeps its own copy of the control point store and the point
// count. For every evaluate transaction it computes the curve point it
// expects, then compares results against those expectations in order.
// ----------------------------------------------------------------------------
module spline_eval_checker #(
	parameter int  NP    = crs_pkg::MAX_POINTS_DEF,
	parameter int  CW    = crs_pkg::COORD_WIDTH_DEF,
	parameter int  FB    = crs_pkg::FRAC_BITS_DEF,
	localparam int IW    = $clog2(NP),
	localparam int KW    = $clog2(NP + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [KW-1:0]        cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  crs_pkg::op_t         opcode,
	input  logic [IW-1:0]        point_index,
	input  logic signed [CW-1:0] point_x,
	input  logic signed [CW-1:0] point_y,
	input  logic [IW+FB-1:0]     param,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [CW-1:0] curve_x,
	input  logic signed [CW-1:0] curve_y,
	input  logic                 out_of_range,
	output int                   fail_count,
	output int                   pending,
	output int                   results_seen,
	output int                   oor_seen
);
	import crs_pkg::*;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 oor;
	} curve_pt_t;

	// full-width copies of the loaded coordinates, index 0 is x, 1 is y
	longint    pts [2][NP];
	int        pt_count;
	curve_pt_t curve_q [$];

	function automatic longint floor_third(input longint v);
		if (v >= 0) begin
			return v / 3;
		end
		return -((-v + 2) / 3);
	endfunction

	function automatic longint tangent_at(input int axis, input int i, input int n);
		if (i == 0 || i + 1 >= n) begin
			return 0;
		end
		return (pts[axis][i+1] - pts[axis][i-1]) >>> 1;
	endfunction

	// exact floor of a + (b - a) * f / 2^FB
	function automatic longint lerp_q(input longint a, input longint b, input longint f);
		return a + (((b - a) * f) >>> FB);
	endfunction

	function automatic longint curve_axis(input int axis, input int seg, input int n,
			input longint f);
		longint q [4];
		int     r;
		int     k;
		q[0] = pts[axis][seg];
		q[3] = pts[axis][seg+1];
		q[1] = q[0] + floor_third(tangent_at(axis, seg, n));
		q[2] = q[3] - floor_third(tangent_at(axis, seg + 1, n));
		for (r = 3; r > 0; r--) begin
			for (k = 0; k < r; k++) begin
				q[k] = lerp_q(q[k], q[k+1], f);
			end
		end
		return q[0];
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi[CW-1:0];
		end
		if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	function automatic curve_pt_t curve_point_at(input logic [IW+FB-1:0] p);
		int        n;
		int        seg;
		longint    f;
		curve_pt_t r;
		n = pt_count;
		if (n < MIN_POINTS) begin
			n = MIN_POINTS;
		end
		if (n > NP) begin
			n = NP;
		end
		seg = p >> FB;
		f   = p[FB-1:0];
		if (seg >= n - 1) begin
			r.x   = clamp_coord(pts[0][n-1]);
			r.y   = clamp_coord(pts[1][n-1]);
			r.oor = 1'b1;
		end else begin
			r.x   = clamp_coord(curve_axis(0, seg, n, f));
			r.y   = clamp_coord(curve_axis(1, seg, n, f));
			r.oor = 1'b0;
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic signed [CW-1:0] want,
			input logic signed [CW-1:0] got);
		$display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)",
			$time, what, want, want, got, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		curve_pt_t want;
		if (!arst_n) begin
			pt_count = POINT_COUNT_RST;
			curve_q.delete();
			pending      = 0;
			fail_count   = 0;
			results_seen = 0;
			oor_seen     = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (out_of_range === 1'b1) begin
					oor_seen++;
				end
				if (curve_q.size() == 0) begin
					$display("%0t: result transaction, expected none, actual %0d %0d %0b",
						$time, curve_x, curve_y, out_of_range);
					fail_count++;
				end else begin
					want = curve_q.pop_front();
					if (curve_x !== want.x) begin
						note_mismatch("curve_x", want.x, curve_x);
					end
					if (curve_y !== want.y) begin
						note_mismatch("curve_y", want.y, curve_y);
					end
					if (out_of_range !== want.oor) begin
						note_mismatch("out_of_range", CW'(want.oor), CW'(out_of_range));
					end
				end
			end
			if (cfg_wr_en) begin
				pt_count = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_LOAD) begin
					pts[0][point_index] = point_x;
					pts[1][point_index] = point_y;
				end else begin
					curve_q.insert(curve_q.size(), curve_point_at(param));
				end
			end
			pending = curve_q.size();
		end
	end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for catmull_rom_spline_eval. Fills the point store,
// runs directed corner evaluates, then random loads and evaluates across
// several point count settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
	import crs_pkg::*;

	localparam int NP           = MAX_POINTS_DEF;
	localparam int CW           = COORD_WIDTH_DEF;
	localparam int FB           = FRAC_BITS_DEF;
	localparam int IW           = $clog2(NP);
	localparam int KW           = $clog2(NP + 1);
	localparam int DRAIN_CYCLES = 24;
	localparam int RAND_ITEMS   = 432;
	localparam int NUM_PHASES   = 8;
	localparam int RUN_LIMIT    = 2_000_000;

	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [FB-1:0]        FRAC_MAX  = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [KW-1:0]        cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	op_t                  opcode = OP_LOAD;
	logic [IW-1:0]        point_index = '0;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic [IW+FB-1:0]     param = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [CW-1:0] curve_x;
	logic signed [CW-1:0] curve_y;
	logic                 out_of_range;

	int fail_count;
	int pending;
	int results_seen;
	int oor_seen;

	int tx_idle_max = 3;
	int rx_idle_max = 3;
	int n_eff = POINT_COUNT_RST;
	int loads_sent = 0;
	int evals_sent = 0;
	int cfg_writes = 0;

	catmull_rom_spline_eval i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.param        (param),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.curve_x      (curve_x),
		.curve_y      (curve_y),
		.out_of_range (out_of_range)
	);

	spline_eval_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.param        (param),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.curve_x      (curve_x),
		.curve_y      (curve_y),
		.out_of_range (out_of_range),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.oor_seen     (oor_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_txn(input op_t op, input logic [IW-1:0] idx,
			input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic [IW+FB-1:0] p);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		point_index <= idx;
		point_x     <= x;
		point_y     <= y;
		param       <= p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (op == OP_LOAD) begin
			loads_sent++;
		end else begin
			evals_sent++;
		end
	endtask

	task automatic load_pt(input int idx, input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		send_txn(OP_LOAD, IW'(idx), x, y, (IW+FB)'($urandom));
	endtask

	task automatic eval_at(input int seg, input logic [FB-1:0] frac);
		send_txn(OP_EVAL, IW'($urandom), CW'($urandom), CW'($urandom), {IW'(seg), frac});
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input int v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= KW'(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_eff = (v < MIN_POINTS) ? MIN_POINTS : (v > NP) ? NP : v;
		cfg_writes++;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		int v;
		unique case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3, 4: return CW'($urandom);
			default: begin
				v = $urandom_range(0, 32'h0200_0000);
				return CW'(v - 32'h0100_0000);
			end
		endcase
	endfunction

	function automatic logic [FB-1:0] rand_frac();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return FRAC_MAX;
			default: return FB'($urandom);
		endcase
	endfunction

	// mostly inside the curve, sometimes past the last one
	function automatic int rand_seg();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(n_eff - 1, NP - 1);
		end
		return $urandom_range(0, n_eff - 2);
	endfunction

	initial begin
		int n;
		forever begin
			n = $urandom_range(0, rx_idle_max);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int ph;
		int k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every entry; the first few make curves overshoot both rails
		load_pt(0, COORD_MIN, COORD_MAX);
		load_pt(1, COORD_MAX, COORD_MIN);
		load_pt(2, COORD_MAX, COORD_MIN);
		load_pt(3, COORD_MIN, COORD_MAX);
		load_pt(4, COORD_MIN, COORD_MAX);
		load_pt(5, COORD_MAX, COORD_MIN);
		for (k = 6; k < NP; k++) begin
			load_pt(k, rand_coord(), rand_coord());
		end

		// reset point count: a single curve
		eval_at(0, '0);
		eval_at(0, FRAC_MAX);
		eval_at(1, '0);
		eval_at(NP - 1, FRAC_MAX);

		write_count(NP);
		eval_at(0, 16'h8000);
		eval_at(1, 16'h8000);
		eval_at(3, 16'h8000);
		eval_at(NP - 2, FRAC_MAX);
		eval_at(NP - 1, '0);
		// end point reloaded right before it is read
		load_pt(NP - 1, COORD_MAX, COORD_MIN);
		eval_at(NP - 1, 16'h1234);
		eval_at(NP - 2, '0);
		load_pt(2, CW'(0), CW'(-1));
		eval_at(1, 16'h0001);

		// counts below and above the legal range clamp
		write_count(0);
		eval_at(0, 16'h4000);
		eval_at(1, '0);
		write_count(2 ** KW - 1);
		eval_at(NP - 1, '0);
		eval_at(NP - 2, 16'h0001);
		write_count(1);
		eval_at(0, FRAC_MAX);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			unique case (ph)
				0: write_count(NP);
				1: write_count(MIN_POINTS);
				2: write_count(NP + 1);
				3: write_count(3);
				4: write_count(0);
				5: write_count(2 ** KW - 1);
				default: write_count($urandom_range(4, NP - 1));
			endcase
			tx_idle_max = (ph % 4 == 3) ? 0 : 3;
			rx_idle_max = (ph % 4 == 3 || ph % 4 == 1) ? 0 : 3;
			for (k = 0; k < RAND_ITEMS / NUM_PHASES; k++) begin
				if (ph == 2 && k == 30) begin
					drain();
				end
				if ($urandom_range(0, 9) < 3) begin
					load_pt($urandom_range(0, NP - 1), rand_coord(), rand_coord());
				end else begin
					eval_at(rand_seg(), rand_frac());
				end
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run sent %0d loads and %0d evaluates over %0d point count writes",
			loads_sent, evals_sent, cfg_writes);
		$display("%0d results checked, %0d of them past the last curve",
			results_seen, oor_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
